// ----- rtl/pdt_pkg.sv -----
// Shared types and constants for the pixel desaturate and tint pipeline.
`timescale 1ns / 1ps
`default_nettype none

package pdt_pkg;

  typedef logic [7:0] chan_t;
  typedef chan_t [2:0] rgb_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } pdt_ctl_t;

  typedef enum logic [2:0] {
    CFG_SATURATION     = 3'd0,
    CFG_TINT_INTENSITY = 3'd1,
    CFG_TINT_RED       = 3'd2,
    CFG_TINT_GREEN     = 3'd3,
    CFG_TINT_BLUE      = 3'd4,
    CFG_KEY_FILL       = 3'd5
  } cfg_reg_t;

  localparam int CfgIndexWidth = 3;
  localparam int ChanWidth     = 8;

  localparam chan_t LUMA_RED   = 8'd79;
  localparam chan_t LUMA_GREEN = 8'd156;
  localparam chan_t LUMA_BLUE  = 8'd21;

  localparam chan_t KEY_RED   = 8'd255;
  localparam chan_t KEY_GREEN = 8'd0;
  localparam chan_t KEY_BLUE  = 8'd255;

  localparam chan_t SATURATION_RESET     = 8'd255;
  localparam chan_t TINT_INTENSITY_RESET = 8'd0;
  localparam chan_t TINT_COLOR_RESET     = 8'd0;
  localparam logic  KEY_FILL_RESET       = 1'b1;

  localparam logic [16:0] ROUND_BIAS = 17'd255;

endpackage

`default_nettype wire

// ----- rtl/pixel_desaturate_tint.sv -----
// Top level: config registers, luma, desaturate, tint and key-fill output stages.
//
// One pixel is taken on every clock (busy stays low) and its result appears
// on the out_* ports with done high after passing through the luma,
// desaturate, tint and key-fill output registers. Results cannot be
// held off. Configuration writes are always ready and should be made while
// no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module pixel_desaturate_tint
  import pdt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic [7:0]               pixel_red,
  input  wire logic [7:0]               pixel_green,
  input  wire logic [7:0]               pixel_blue,
  input  wire logic                     mask_clear,
  output      logic                     done,
  output      logic [7:0]               out_red,
  output      logic [7:0]               out_green,
  output      logic [7:0]               out_blue,
  output      logic                     out_clear,
  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [ChanWidth-1:0]     cfg_data
);

  chan_t saturation;
  chan_t tint_intensity;
  rgb_t  tint_color;
  logic  key_fill;

  pdt_ctl_t luma_ctl;
  rgb_t     luma_pixel;
  chan_t    gray;
  pdt_ctl_t desat_ctl;
  rgb_t     desat_pixel;
  pdt_ctl_t tint_ctl;
  rgb_t     tint_pixel;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation     <= SATURATION_RESET;
      tint_intensity <= TINT_INTENSITY_RESET;
      tint_color     <= {3{TINT_COLOR_RESET}};
      key_fill       <= KEY_FILL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SATURATION:     saturation     <= cfg_data;
        CFG_TINT_INTENSITY: tint_intensity <= cfg_data;
        CFG_TINT_RED:       tint_color[0]  <= cfg_data;
        CFG_TINT_GREEN:     tint_color[1]  <= cfg_data;
        CFG_TINT_BLUE:      tint_color[2]  <= cfg_data;
        CFG_KEY_FILL:       key_fill       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pdt_luma u_luma (
    .clk     (clk),
    .rst     (rst),
    .accept  (start && !busy),
    .pixel   ({pixel_blue, pixel_green, pixel_red}),
    .clear   (mask_clear),
    .ctl     (luma_ctl),
    .pixel_q (luma_pixel),
    .gray    (gray)
  );

  pdt_blend u_desat (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (luma_ctl),
    .color_a  (luma_pixel),
    .weight_a (saturation),
    .color_b  ({3{gray}}),
    .weight_b (~saturation),
    .out_ctl  (desat_ctl),
    .color_q  (desat_pixel)
  );

  pdt_blend u_tint (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (desat_ctl),
    .color_a  (desat_pixel),
    .weight_a (~tint_intensity),
    .color_b  (tint_color),
    .weight_b (tint_intensity),
    .out_ctl  (tint_ctl),
    .color_q  (tint_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tint_ctl.valid;
    end
    out_clear <= tint_ctl.clear;
    if (tint_ctl.clear && key_fill) begin
      out_red   <= KEY_RED;
      out_green <= KEY_GREEN;
      out_blue  <= KEY_BLUE;
    end else begin
      out_red   <= tint_pixel[0];
      out_green <= tint_pixel[1];
      out_blue  <= tint_pixel[2];
    end
  end

  a_request_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted request did not produce a result");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a matching request");

  a_clear_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> out_clear == $past(mask_clear, 4))
    else $error("mask bit lost in pipeline");

  a_key_fill: assert property (@(posedge clk) disable iff (rst)
    (done && out_clear && key_fill && $stable(key_fill))
      |-> (out_red == KEY_RED && out_green == KEY_GREEN && out_blue == KEY_BLUE))
    else $error("transparent pixel not replaced by key color");

endmodule

`default_nettype wire

// ----- rtl/pdt_luma.sv -----
// Input stage: register the pixel and its luma gray level.
`timescale 1ns / 1ps
`default_nettype none

module pdt_luma
  import pdt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire rgb_t     pixel,
  input  wire logic     clear,
  output pdt_ctl_t      ctl,
  output rgb_t          pixel_q,
  output chan_t         gray
);

  logic [15:0] luma_sum;

  always_comb begin
    luma_sum = {8'b0, pixel[0]} * {8'b0, LUMA_RED}
             + {8'b0, pixel[1]} * {8'b0, LUMA_GREEN}
             + {8'b0, pixel[2]} * {8'b0, LUMA_BLUE};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= accept;
      ctl.clear <= clear;
    end
    pixel_q <= pixel;
    gray    <= luma_sum[15:8];
  end

endmodule

`default_nettype wire

// ----- rtl/pdt_blend.sv -----
// Blend stage: weighted mix of two colors per channel with rounding.
`timescale 1ns / 1ps
`default_nettype none

module pdt_blend
  import pdt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire pdt_ctl_t in_ctl,
  input  wire rgb_t     color_a,
  input  wire chan_t    weight_a,
  input  wire rgb_t     color_b,
  input  wire chan_t    weight_b,
  output pdt_ctl_t      out_ctl,
  output rgb_t          color_q
);

  logic [2:0][16:0] mix_sum;
  rgb_t             mixed;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix_sum[i] = {9'b0, color_a[i]} * {9'b0, weight_a}
                 + {9'b0, color_b[i]} * {9'b0, weight_b}
                 + ROUND_BIAS;
      mixed[i]   = mix_sum[i][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    // pass transparent pixels untouched
    color_q <= in_ctl.clear ? color_a : mixed;
  end

endmodule

`default_nettype wire
